/* rtl/wwc_pkg.sv */
// Shared constants, class codes and types for the workload window classifier.
package wwc_pkg;

  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

  // field widths
  localparam int unsigned CPU_W = 7;
  localparam int unsigned MEM_W = 32;
  localparam int unsigned INTER_W = 8;
  localparam int unsigned WAKE_W = 32;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned CONF_W = 7;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned ENTRY_W = CPU_W + MEM_W + INTER_W + 1;
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 8'd1;
  localparam logic [6:0] MIN_SAMPLES_RST = 7'd5;
  localparam logic [6:0] CHANGE_THRESHOLD_RST = 7'd70;

  // class codes
  localparam logic [CLASS_W-1:0] CLASS_CPU_BURST = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_MEMORY_GROWTH = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_INTERACTIVE = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_GAMING = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd4;

  // sample limits
  localparam logic [CPU_W-1:0] CPU_MAX = 7'd100;
  localparam logic [CPU_W-1:0] CPU_HIGH = 7'd70;
  localparam logic [CPU_W-1:0] CPU_LOW = 7'd30;
  localparam logic [CPU_W-1:0] CPU_BUSY = 7'd50;
  localparam logic [INTER_W-1:0] INTER_ACTIVE = 8'd60;
  localparam logic [INTER_W-1:0] INTER_GAME = 8'd80;
  localparam logic [WAKE_W-1:0] WAKE_BUSY = 32'd10;

  // scores
  localparam logic [CONF_W-1:0] SCORE_NONE = 7'd0;
  localparam logic [CONF_W-1:0] SCORE_60 = 7'd60;
  localparam logic [CONF_W-1:0] SCORE_70 = 7'd70;
  localparam logic [CONF_W-1:0] SCORE_80 = 7'd80;
  localparam logic [CONF_W-1:0] SCORE_90 = 7'd90;
  localparam logic [CONF_W-1:0] SCORE_95 = 7'd95;
  localparam logic [CONF_W-1:0] SCORE_100 = 7'd100;

  typedef struct packed {
    logic [CNT_W-1:0] high70;
    logic [CNT_W-1:0] bursts;
    logic [CNT_W-1:0] growths;
    logic [CNT_W-1:0] inter60;
    logic [CNT_W-1:0] wake;
    logic [CNT_W-1:0] cpu50;
    logic [CNT_W-1:0] inter80;
    logic [CNT_W-1:0] both;
  } counts_t;

  typedef struct packed {
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] three_quarters;
    logic [CNT_W-1:0] two_thirds;
    logic [CNT_W-1:0] third;
  } limits_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [MEM_W-1:0] mem;
    logic [INTER_W-1:0] inter;
    logic busy;
  } entry_t;

endpackage

/* rtl/wwc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wwc_scan.sv */
// Shared per-entry compare and count unit, fed one window entry per cycle.
module wwc_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              valid_i,
  input  logic              first_i,
  input  wwc_pkg::entry_t   entry_i,
  output wwc_pkg::counts_t  counts_o
);

  wwc_pkg::counts_t counts_q, counts_d;
  logic [wwc_pkg::CPU_W-1:0] prev_cpu_q;
  logic [wwc_pkg::MEM_W-1:0] prev_mem_q;
  logic hi70, lo30, grow, cpu50, ia80;

  always_comb begin
    hi70 = entry_i.cpu > wwc_pkg::CPU_HIGH;
    lo30 = prev_cpu_q < wwc_pkg::CPU_LOW;
    grow = entry_i.mem > prev_mem_q;
    cpu50 = entry_i.cpu > wwc_pkg::CPU_BUSY;
    ia80 = entry_i.inter > wwc_pkg::INTER_GAME;
    counts_d = counts_q;
    if (clear_i) begin
      counts_d = '0;
    end else if (valid_i) begin
      counts_d.high70 = counts_q.high70 + wwc_pkg::CNT_W'(hi70);
      counts_d.bursts = counts_q.bursts + wwc_pkg::CNT_W'(hi70 & lo30 & ~first_i);
      counts_d.growths = counts_q.growths + wwc_pkg::CNT_W'(grow & ~first_i);
      counts_d.inter60 = counts_q.inter60
                       + wwc_pkg::CNT_W'(entry_i.inter > wwc_pkg::INTER_ACTIVE);
      counts_d.wake = counts_q.wake + wwc_pkg::CNT_W'(entry_i.busy);
      counts_d.cpu50 = counts_q.cpu50 + wwc_pkg::CNT_W'(cpu50);
      counts_d.inter80 = counts_q.inter80 + wwc_pkg::CNT_W'(ia80);
      counts_d.both = counts_q.both + wwc_pkg::CNT_W'(cpu50 & ia80);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
    end else begin
      counts_q <= counts_d;
    end
  end

  // predecessor of the next entry
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prev_cpu_q <= entry_i.cpu;
      prev_mem_q <= entry_i.mem;
    end
  end

  assign counts_o = counts_q;

endmodule

/* rtl/wwc_score.sv */
// Detector scoring and best-class pick, registered on a load strobe.
module wwc_score (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          enable_i,
  input  wwc_pkg::counts_t              counts_i,
  input  wwc_pkg::limits_t              limits_i,
  output logic [wwc_pkg::CONF_W-1:0]    best_o,
  output logic [wwc_pkg::CLASS_W-1:0]   best_class_o
);

  logic [wwc_pkg::CONF_W-1:0] s0, s1, s2, s3, best_d, best_q;
  logic [wwc_pkg::CLASS_W-1:0] class_d, class_q;

  always_comb begin
    s0 = wwc_pkg::SCORE_NONE;
    s1 = wwc_pkg::SCORE_NONE;
    s2 = wwc_pkg::SCORE_NONE;
    s3 = wwc_pkg::SCORE_NONE;
    if (enable_i) begin
      // twenty per burst from three bursts on, capped at a hundred
      if (counts_i.bursts == wwc_pkg::CNT_W'(3)) begin
        s0 = wwc_pkg::SCORE_60;
      end else if (counts_i.bursts == wwc_pkg::CNT_W'(4)) begin
        s0 = wwc_pkg::SCORE_80;
      end else if (counts_i.bursts > wwc_pkg::CNT_W'(4)) begin
        s0 = wwc_pkg::SCORE_100;
      end else if (counts_i.high70 > limits_i.half) begin
        s0 = wwc_pkg::SCORE_60;
      end

      if (counts_i.growths > limits_i.three_quarters) begin
        s1 = wwc_pkg::SCORE_90;
      end else if (counts_i.growths > limits_i.half) begin
        s1 = wwc_pkg::SCORE_60;
      end

      if (counts_i.inter60 > limits_i.two_thirds) begin
        s2 = wwc_pkg::SCORE_80;
      end else if (counts_i.wake > limits_i.half) begin
        s2 = wwc_pkg::SCORE_60;
      end

      if (counts_i.both > limits_i.two_thirds) begin
        s3 = wwc_pkg::SCORE_95;
      end else if (counts_i.cpu50 > limits_i.half && counts_i.inter80 > limits_i.third) begin
        s3 = wwc_pkg::SCORE_70;
      end
    end

    // strict compare keeps the earlier detector on a tie
    best_d = wwc_pkg::SCORE_NONE;
    class_d = wwc_pkg::CLASS_UNKNOWN;
    if (s0 > best_d) begin
      best_d = s0;
      class_d = wwc_pkg::CLASS_CPU_BURST;
    end
    if (s1 > best_d) begin
      best_d = s1;
      class_d = wwc_pkg::CLASS_MEMORY_GROWTH;
    end
    if (s2 > best_d) begin
      best_d = s2;
      class_d = wwc_pkg::CLASS_INTERACTIVE;
    end
    if (s3 > best_d) begin
      best_d = s3;
      class_d = wwc_pkg::CLASS_GAMING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= wwc_pkg::SCORE_NONE;
      class_q <= wwc_pkg::CLASS_UNKNOWN;
    end else if (load_i) begin
      best_q <= best_d;
      class_q <= class_d;
    end
  end

  assign best_o = best_q;
  assign best_class_o = class_q;

endmodule

/* rtl/workload_window_classifier_unit.sv */
// Workload window classifier. Each accepted sample is written into a 64-entry
// window RAM and the window is then rescanned oldest to newest, one entry per
// cycle through a single compare-and-count unit; four detectors score the
// counts and the held class switches when the best score beats the change
// threshold. While n, the number of filled window entries, is below
// min_samples the rescan is skipped and the sample goes straight to scoring;
// otherwise the rescan over the RAM read port sets the time a sample takes.
// The input is not ready while a sample is being worked on. One finished
// result may wait in the output register while the next sample is accepted.
// Configuration writes are always taken.
module workload_window_classifier_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // cpu_percent[6:0], memory_kb[38:7], interaction_score[46:39],
  // wakeup_count[78:47], zero[79]
  input  logic [wwc_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // current_class[2:0], class_confidence[9:3], class_changed[10],
  // change_total[42:11], zero[47:43]
  output logic [wwc_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wwc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [6:0]                         cfg_data_i
);

  localparam int unsigned PTR_W = wwc_pkg::PTR_W;
  localparam int unsigned CNT_W = wwc_pkg::CNT_W;
  localparam int unsigned MUL_W = CNT_W + 12;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_SCORE  = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;

  logic [2:0] state_q, state_d;
  logic [6:0] min_samples_q, change_threshold_q;
  logic [PTR_W-1:0] wptr_q, rptr_q, rptr_d;
  logic [CNT_W-1:0] filled_q, k_q, k_d;
  logic enable_q, enable_d;
  logic rvalid_q, rfirst_q;
  logic [wwc_pkg::CLASS_W-1:0] held_class_q;
  logic [wwc_pkg::CONF_W-1:0] held_conf_q;
  logic [wwc_pkg::TOTAL_W-1:0] total_q;
  logic changed_q, out_valid_q;
  wwc_pkg::limits_t limits_q, limits_d;
  wwc_pkg::entry_t wr_entry, rd_entry;
  wwc_pkg::counts_t counts;
  logic [wwc_pkg::CONF_W-1:0] best;
  logic [wwc_pkg::CLASS_W-1:0] best_class;
  logic in_accept, re, scan_clear, score_load, decide_go, do_switch;
  logic [CNT_W:0] start_wide;
  logic [PTR_W-1:0] start;
  logic [wwc_pkg::CPU_W-1:0] cpu_in;

  assign in_accept = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // saturate cpu and reduce wakeups to a flag before storing
  always_comb begin
    cpu_in = s_axis_tdata_i[6:0];
    if (cpu_in > wwc_pkg::CPU_MAX) begin
      cpu_in = wwc_pkg::CPU_MAX;
    end
    wr_entry.cpu = cpu_in;
    wr_entry.mem = s_axis_tdata_i[38:7];
    wr_entry.inter = s_axis_tdata_i[46:39];
    wr_entry.busy = s_axis_tdata_i[78:47] > wwc_pkg::WAKE_BUSY;
  end

  wwc_ram #(
    .WIDTH(wwc_pkg::ENTRY_W),
    .DEPTH(wwc_pkg::WINDOW_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wptr_q),
    .wdata_i (wr_entry),
    .re_i    (re),
    .raddr_i (rptr_q),
    .rdata_o (rd_entry)
  );

  wwc_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (scan_clear),
    .valid_i  (rvalid_q),
    .first_i  (rfirst_q),
    .entry_i  (rd_entry),
    .counts_o (counts)
  );

  wwc_score u_score (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (score_load),
    .enable_i     (enable_q),
    .counts_i     (counts),
    .limits_i     (limits_q),
    .best_o       (best),
    .best_class_o (best_class)
  );

  // oldest entry sits n slots behind the write pointer
  always_comb begin
    if ({1'b0, wptr_q} >= (PTR_W + 1)'(filled_q)) begin
      start_wide = (CNT_W + 1)'(wptr_q) - (CNT_W + 1)'(filled_q);
    end else begin
      start_wide = (CNT_W + 1)'(wptr_q) + (CNT_W + 1)'(wwc_pkg::WINDOW_DEPTH)
                 - (CNT_W + 1)'(filled_q);
    end
    start = start_wide[PTR_W-1:0];
  end

  // thresholds: n/2, 3n/4, 2n/3 and n/3 through reciprocal multiplies
  always_comb begin
    limits_d.half = filled_q >> 1;
    limits_d.three_quarters = CNT_W'((MUL_W'(filled_q) * MUL_W'(3)) >> 2);
    limits_d.two_thirds = CNT_W'((MUL_W'(filled_q) * MUL_W'(1366)) >> 11);
    limits_d.third = CNT_W'((MUL_W'(filled_q) * MUL_W'(171)) >> 9);
  end

  assign decide_go = (state_q == ST_DECIDE) & (~out_valid_q | m_axis_tready_i);
  assign do_switch = (best > change_threshold_q) & (best_class != held_class_q);

  always_comb begin
    state_d = state_q;
    rptr_d = rptr_q;
    k_d = k_q;
    enable_d = enable_q;
    re = 1'b0;
    scan_clear = 1'b0;
    score_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        scan_clear = 1'b1;
        rptr_d = start;
        k_d = '0;
        enable_d = wwc_pkg::CMP_W'(filled_q) >= wwc_pkg::CMP_W'(min_samples_q);
        state_d = enable_d ? ST_SCAN : ST_SCORE;
      end
      ST_SCAN: begin
        re = 1'b1;
        k_d = k_q + CNT_W'(1);
        rptr_d = (rptr_q == PTR_W'(wwc_pkg::WINDOW_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
        if (k_q == filled_q - CNT_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SCORE;
      end
      ST_SCORE: begin
        score_load = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (decide_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rptr_q <= '0;
      k_q <= '0;
      enable_q <= 1'b0;
      rvalid_q <= 1'b0;
      rfirst_q <= 1'b0;
      wptr_q <= '0;
      filled_q <= '0;
      min_samples_q <= wwc_pkg::MIN_SAMPLES_RST;
      change_threshold_q <= wwc_pkg::CHANGE_THRESHOLD_RST;
      held_class_q <= wwc_pkg::CLASS_UNKNOWN;
      held_conf_q <= wwc_pkg::SCORE_NONE;
      total_q <= '0;
      changed_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rptr_q <= rptr_d;
      k_q <= k_d;
      enable_q <= enable_d;
      rvalid_q <= re;
      rfirst_q <= re & (k_q == '0);

      if (cfg_valid_i) begin
        case (cfg_index_i)
          wwc_pkg::CFG_MIN_SAMPLES: min_samples_q <= cfg_data_i;
          wwc_pkg::CFG_CHANGE_THRESHOLD: change_threshold_q <= cfg_data_i;
          default: ;
        endcase
      end

      // advance the window on every accepted sample
      if (in_accept) begin
        wptr_q <= (wptr_q == PTR_W'(wwc_pkg::WINDOW_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
        if (filled_q < CNT_W'(wwc_pkg::WINDOW_DEPTH)) begin
          filled_q <= filled_q + CNT_W'(1);
        end
      end

      if (decide_go) begin
        out_valid_q <= 1'b1;
        changed_q <= do_switch;
        if (do_switch) begin
          held_class_q <= best_class;
          held_conf_q <= best;
          total_q <= total_q + wwc_pkg::TOTAL_W'(1);
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      limits_q <= limits_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = {5'd0, total_q, changed_q, held_conf_q, held_class_q};

endmodule

/* tb/wwc_class_checker.sv */
// Checker for the workload window classifier: window predictor and result comparison.
module wwc_class_checker
  import wwc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [6:0]            cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [CONF_W-1:0]  conf;
    logic               changed;
    logic [TOTAL_W-1:0] total;
  } verdict_t;

  // window copy, oldest entry sits filled slots behind the write slot
  logic [CPU_W-1:0]   win_cpu   [WINDOW_DEPTH];
  logic [MEM_W-1:0]   win_mem   [WINDOW_DEPTH];
  logic [INTER_W-1:0] win_inter [WINDOW_DEPTH];
  logic               win_busy  [WINDOW_DEPTH];
  int unsigned        wr_slot;
  int unsigned        filled;
  logic [CLASS_W-1:0] held_cls;
  logic [CONF_W-1:0]  held_conf;
  logic [TOTAL_W-1:0] switches;
  logic [6:0]         min_samples;
  logic [6:0]         change_thr;

  verdict_t    expected_verdicts[$];
  verdict_t    fresh;
  int unsigned fails = 0;
  int unsigned reports = 0;

  task automatic classify_sample(input logic [IN_DATA_W-1:0] item, output verdict_t v);
    logic [CPU_W-1:0]   cpu;
    logic [CPU_W-1:0]   prev_cpu;
    logic [MEM_W-1:0]   prev_mem;
    logic [CONF_W-1:0]  sc_burst, sc_growth, sc_inter, sc_game, best;
    logic [CLASS_W-1:0] best_cls;
    logic               changed;
    int unsigned        n, first, s;
    int unsigned        high70, bursts, growths, inter60, wake, cpu50, inter80, both;
    cpu = item[CPU_W-1:0];
    if (cpu > CPU_MAX) cpu = CPU_MAX;
    win_cpu[wr_slot]   = cpu;
    win_mem[wr_slot]   = item[CPU_W +: MEM_W];
    win_inter[wr_slot] = item[CPU_W+MEM_W +: INTER_W];
    win_busy[wr_slot]  = item[CPU_W+MEM_W+INTER_W +: WAKE_W] > WAKE_BUSY;
    wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
    if (filled < WINDOW_DEPTH) filled++;
    n = filled;

    high70 = 0; bursts = 0; growths = 0; inter60 = 0;
    wake = 0; cpu50 = 0; inter80 = 0; both = 0;
    prev_cpu = '0;
    prev_mem = '0;
    sc_burst = SCORE_NONE; sc_growth = SCORE_NONE;
    sc_inter = SCORE_NONE; sc_game = SCORE_NONE;

    if (n >= min_samples) begin
      first = (wr_slot + WINDOW_DEPTH - n) % WINDOW_DEPTH;
      for (int k = 0; k < n; k++) begin
        s = (first + k) % WINDOW_DEPTH;
        if (win_cpu[s] > CPU_HIGH) begin
          high70++;
          if (k > 0 && prev_cpu < CPU_LOW) bursts++;
        end
        if (k > 0 && win_mem[s] > prev_mem) growths++;
        if (win_inter[s] > INTER_ACTIVE) inter60++;
        if (win_busy[s]) wake++;
        if (win_cpu[s] > CPU_BUSY) cpu50++;
        if (win_inter[s] > INTER_GAME) inter80++;
        if (win_cpu[s] > CPU_BUSY && win_inter[s] > INTER_GAME) both++;
        prev_cpu = win_cpu[s];
        prev_mem = win_mem[s];
      end

      if (bursts >= 3)
        sc_burst = (bursts * 20 > 100) ? SCORE_100 : CONF_W'(bursts * 20);
      else if (high70 > n / 2)
        sc_burst = SCORE_60;

      if (growths > n * 3 / 4)      sc_growth = SCORE_90;
      else if (growths > n / 2)     sc_growth = SCORE_60;

      if (inter60 > n * 2 / 3)      sc_inter = SCORE_80;
      else if (wake > n / 2)        sc_inter = SCORE_60;

      if (both > n * 2 / 3)                          sc_game = SCORE_95;
      else if (cpu50 > n / 2 && inter80 > n / 3)     sc_game = SCORE_70;
    end

    // strict compare keeps the earlier detector on a tie
    best = SCORE_NONE;
    best_cls = CLASS_UNKNOWN;
    if (sc_burst > best) begin
      best = sc_burst;
      best_cls = CLASS_CPU_BURST;
    end
    if (sc_growth > best) begin
      best = sc_growth;
      best_cls = CLASS_MEMORY_GROWTH;
    end
    if (sc_inter > best) begin
      best = sc_inter;
      best_cls = CLASS_INTERACTIVE;
    end
    if (sc_game > best) begin
      best = sc_game;
      best_cls = CLASS_GAMING;
    end

    changed = 1'b0;
    if (best > change_thr && best_cls != held_cls) begin
      held_cls = best_cls;
      held_conf = best;
      switches = switches + 1;
      changed = 1'b1;
    end
    v.cls = held_cls;
    v.conf = held_conf;
    v.changed = changed;
    v.total = switches;
  endtask

  task automatic report_field(string field, longint unsigned want, longint unsigned got);
    fails++;
    if (reports < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    reports++;
  endtask

  task automatic compare_result(input logic [OUT_DATA_W-1:0] word);
    verdict_t want, got;
    got.cls = word[CLASS_W-1:0];
    got.conf = word[CLASS_W +: CONF_W];
    got.changed = word[CLASS_W+CONF_W];
    got.total = word[CLASS_W+CONF_W+1 +: TOTAL_W];
    if (expected_verdicts.size() == 0) begin
      fails++;
      if (reports < MAX_REPORTS)
        $display("%0t: result with nothing outstanding, expected none, actual %h",
                 $time, word);
      reports++;
    end else begin
      want = expected_verdicts.pop_front();
      if (got.cls !== want.cls)         report_field("current_class", want.cls, got.cls);
      if (got.conf !== want.conf)       report_field("class_confidence", want.conf, got.conf);
      if (got.changed !== want.changed) report_field("class_changed", want.changed, got.changed);
      if (got.total !== want.total)     report_field("change_total", want.total, got.total);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot = 0;
      filled = 0;
      held_cls = CLASS_UNKNOWN;
      held_conf = '0;
      switches = '0;
      min_samples = MIN_SAMPLES_RST;
      change_thr = CHANGE_THRESHOLD_RST;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_SAMPLES:      min_samples = cfg_data_i;
          CFG_CHANGE_THRESHOLD: change_thr = cfg_data_i;
          default: ;
        endcase
      end
      // retire before queueing: a result can never belong to this edge's sample
      if (m_tvalid_i && m_tready_i) compare_result(m_tdata_i);
      if (s_tvalid_i && s_tready_i) begin
        classify_sample(s_tdata_i, fresh);
        expected_verdicts.push_back(fresh);
      end
    end
    // publish after the edge so the stimulus always reads a settled count
    pending_o <= expected_verdicts.size();
    fail_count_o <= fails;
  end

endmodule

/* tb/workload_window_classifier_unit_tb.sv */
// Testbench top for the workload window classifier: stimulus, handshakes and verdict.
module workload_window_classifier_unit_tb;
  import wwc_pkg::*;

  localparam int unsigned SAMPLE_TARGET = 1050;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

  typedef enum int {
    TREND_NOISE, TREND_BURST, TREND_GROWTH, TREND_INTERACT, TREND_WAKE,
    TREND_GAMING, TREND_BUSY_CPU, TREND_QUIET, TREND_EDGE
  } trend_e;

  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_e;

  // cpu in the lowest bits, matching the tdata layout
  typedef struct packed {
    logic [WAKE_W-1:0]  wake;
    logic [INTER_W-1:0] inter;
    logic [MEM_W-1:0]   mem;
    logic [CPU_W-1:0]   cpu;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [6:0]            cfg_data = '0;
  int unsigned           fail_count;
  int unsigned           pending;

  pace_e       pace = PACE_FULL;
  logic        burst_high = 1'b0;
  logic [31:0] mem_level = '0;
  int unsigned sent = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  workload_window_classifier_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  wwc_class_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tdata_i    (s_tdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .m_tdata_i    (m_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int unsigned pick_gap(pace_e p);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (p)
      PACE_LIGHT: begin
        if (r < 75)      return 0;
        else if (r < 95) return $urandom_range(1, 3);
        else             return $urandom_range(8, 40);
      end
      PACE_HEAVY: begin
        if (r < 40)      return 0;
        else if (r < 85) return $urandom_range(1, 4);
        else if (r < 97) return $urandom_range(5, 30);
        else             return $urandom_range(60, 150);
      end
      default: return 0;
    endcase
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap(pace);
    end
  end

  // watchdog on transactions of any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [CPU_W-1:0] edge_cpu();
    case ($urandom_range(0, 7))
      0: return 7'd29;
      1: return 7'd30;
      2: return 7'd50;
      3: return 7'd51;
      4: return 7'd70;
      5: return 7'd71;
      6: return 7'd100;
      default: return 7'd101;
    endcase
  endfunction

  function automatic sample_t make_sample(trend_e t);
    sample_t smp;
    smp.cpu = CPU_W'($urandom);
    smp.mem = $urandom;
    smp.inter = INTER_W'($urandom);
    smp.wake = $urandom;
    // leave some noise inside every trend
    if ($urandom_range(0, 99) < 12) return smp;
    case (t)
      TREND_BURST: begin
        burst_high = !burst_high;
        smp.cpu = CPU_W'(burst_high ? $urandom_range(71, 127) : $urandom_range(0, 29));
      end
      TREND_GROWTH: begin
        mem_level = mem_level + $urandom_range(1, 5000);
        smp.mem = mem_level;
      end
      TREND_INTERACT: smp.inter = INTER_W'($urandom_range(61, 255));
      TREND_WAKE: begin
        smp.wake = $urandom_range(11, 5000);
        smp.inter = INTER_W'($urandom_range(0, 60));
      end
      TREND_GAMING: begin
        smp.cpu = CPU_W'($urandom_range(51, 127));
        smp.inter = INTER_W'($urandom_range(81, 255));
      end
      TREND_BUSY_CPU: begin
        smp.cpu = CPU_W'($urandom_range(51, 127));
        smp.inter = INTER_W'(($urandom_range(0, 2) == 0) ? $urandom_range(81, 255)
                                                         : $urandom_range(0, 80));
      end
      TREND_QUIET: begin
        smp.cpu = CPU_W'($urandom_range(0, 50));
        smp.inter = INTER_W'($urandom_range(0, 60));
        smp.wake = $urandom_range(0, 10);
        smp.mem = mem_level;
      end
      TREND_EDGE: begin
        smp.cpu = edge_cpu();
        smp.inter = INTER_W'($urandom_range(0, 1) ? $urandom_range(60, 61)
                                                  : $urandom_range(80, 81));
        smp.wake = $urandom_range(10, 11);
      end
      default: ;
    endcase
    return smp;
  endfunction

  task automatic send_sample(input logic [CPU_W-1:0] cpu, input logic [MEM_W-1:0] mem,
                             input logic [INTER_W-1:0] inter, input logic [WAKE_W-1:0] wake);
    int unsigned gap;
    gap = pick_gap(pace);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {1'b0, wake, inter, mem, cpu};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    sent++;
  endtask

  task automatic send_random(trend_e t);
    sample_t smp;
    smp = make_sample(t);
    send_sample(smp.cpu, smp.mem, smp.inter, smp.wake);
  endtask

  // hold the sender until every outstanding result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // leave cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic apply_settings(int unsigned phase);
    logic [6:0] min_val, thr_val;
    case (phase % 8)
      0: begin min_val = 7'd1;   thr_val = 7'd0;   end
      1: begin min_val = 7'd64;  thr_val = 7'd100; end
      2: begin min_val = 7'd0;   thr_val = 7'd59;  end
      3: begin min_val = 7'd65;  thr_val = 7'd60;  end
      4: begin min_val = 7'd127; thr_val = 7'd0;   end
      5: begin min_val = 7'd3;   thr_val = 7'd127; end
      6: begin min_val = 7'd32;  thr_val = 7'd94;  end
      default: begin
        min_val = 7'($urandom_range(1, 16));
        thr_val = 7'($urandom_range(0, 100));
      end
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_CHANGE_THRESHOLD, thr_val);
      write_reg(CFG_MIN_SAMPLES, min_val);
    end else begin
      write_reg(CFG_MIN_SAMPLES, min_val);
      write_reg(CFG_CHANGE_THRESHOLD, thr_val);
    end
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_LOW, 7'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_left;
    int unsigned run;
    trend_e      trend;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: the first four samples stay below the minimum count
    send_sample(7'd0, 32'd0, 8'd0, 32'd0);
    send_sample(7'd127, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    send_sample(7'd101, 32'd1, 8'd61, 32'd10);
    send_sample(7'd100, 32'd2, 8'd81, 32'd11);
    send_sample(7'd29, 32'd3, 8'd60, 32'd0);
    send_sample(7'd71, 32'd4, 8'd80, 32'd11);
    send_sample(7'd30, 32'd5, 8'd200, 32'd12);
    send_sample(7'd70, 32'd6, 8'd255, 32'd100);
    send_sample(7'd0, 32'd7, 8'd90, 32'd0);
    send_sample(7'd72, 32'd8, 8'd90, 32'd20);
    drain_results();

    // minimum of one and the lowest threshold, plus a write to an unused index
    write_reg(CFG_MIN_SAMPLES, 7'd1);
    write_reg(CFG_CHANGE_THRESHOLD, 7'd0);
    write_reg(CFG_UNUSED_HIGH, 7'h7F);
    cfg_valid <= 1'b0;
    send_sample(7'd0, 32'd0, 8'd0, 32'd0);
    send_sample(7'd127, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    send_sample(7'd10, 32'd0, 8'd0, 32'd0);
    send_sample(7'd90, 32'd0, 8'd0, 32'd0);
    send_sample(7'd5, 32'd0, 8'd0, 32'd0);
    send_sample(7'd120, 32'd0, 8'd0, 32'd0);
    send_sample(7'd0, 32'd0, 8'd0, 32'd0);
    send_sample(7'd110, 32'd0, 8'd0, 32'd0);

    phase = 0;
    while (sent < SAMPLE_TARGET) begin
      drain_results();
      apply_settings(phase);
      pace = pace_e'(phase % 3);
      phase_left = $urandom_range(90, 200);
      while (phase_left != 0 && sent < SAMPLE_TARGET) begin
        trend = trend_e'($urandom_range(0, 8));
        run = $urandom_range(10, 90);
        while (run != 0 && phase_left != 0 && sent < SAMPLE_TARGET) begin
          send_random(trend);
          run--;
          phase_left--;
        end
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
